/* src/assert_macros.svh */
// Assertion macros shared by the route table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* src/dvrt_pkg.sv */
// Package: types and constants of the route table.
package dvrt_pkg;
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_DELETE  = 3'd1;
  localparam logic [2:0] CMD_TIMEOUT = 3'd2;
  localparam logic [2:0] CMD_UPDATE  = 3'd3;
  localparam logic [2:0] CMD_LOOKUP  = 3'd4;
  localparam logic [2:0] CMD_NOP     = 3'd7;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  localparam logic [4:0] HOP_INF   = 5'd16;
  localparam logic [7:0] TTL_FRESH = 8'hFF;
  localparam logic [31:0] MASK_RST = 32'hFFFF_FF00;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [31:0]       key_ip;
    logic [31:0]       hop_ip;
    logic [4:0]        metric_in;
    logic signed [7:0] ttl_in;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       route_dest;
    logic [31:0]       route_hop;
    logic [4:0]        route_metric;
    logic signed [7:0] route_ttl;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       dest;
    logic [31:0]       hop;
    logic [4:0]        metric;
    logic signed [7:0] ttl;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_FIN, S_OUT
  } eng_state_t;
endpackage

/* src/dvrt_if.sv */
// Valid/ready channel carrying one payload.
interface dvrt_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/dvrt_ram.sv */
// Generic RAM with one write port, one read port and registered read.
module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/dvrt_front.sv */
// Front: takes requests, sanitizes the command, and queues them (2 deep).
module dvrt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dvrt_pkg::req_t in_req,
  output logic           q_valid,
  input  logic           q_pop,
  output dvrt_pkg::req_t q_req
);
  import dvrt_pkg::*;
  req_t       slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;
  req_t       cls;

  always_comb begin
    cls = in_req;
    // unused codes run as "no op" in the back end; clamp to a value it ignores
    if (in_req.cmd > CMD_LOOKUP) cls.cmd = CMD_NOP;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = slot_r[rp_r];
  assign cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= cls;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= 2'd2)
  `ASSERT_NEXT(a_push_cnt, clk, rst_n, push && !(q_pop && q_valid), cnt_r != 2'd0)
endmodule

/* src/dvrt_back.sv */
// Back: sequential scan of the table in RAM, one entry per cycle.
module dvrt_back #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    mask,
  input  logic           q_valid,
  output logic           q_pop,
  input  dvrt_pkg::req_t q_req,
  output logic           out_valid,
  input  logic           out_ready,
  output dvrt_pkg::rsp_t out_rsp
);
  import dvrt_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  eng_state_t st_r, st_nxt;
  req_t       req_r, req_nxt;
  rsp_t       rsp_r, rsp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, ri_r, ri_nxt, wi_r, wi_nxt;
  logic       hit_r, hit_nxt;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  entry_t     wdata, rdata, e;
  logic [CW-1:0] idx;

  dvrt_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // read index ri_r is issued; data for ri_r-1 arrives in S_SCAN
  assign raddr = ri_r[AW-1:0];
  assign idx   = ri_r - CW'(1);
  assign out_valid = (st_r == S_OUT);
  assign out_rsp   = rsp_r;

  always_comb begin
    st_nxt = st_r; req_nxt = req_r; rsp_nxt = rsp_r; cnt_nxt = cnt_r;
    ri_nxt = ri_r; wi_nxt = wi_r; hit_nxt = hit_r;
    we = 1'b0; waddr = idx[AW-1:0]; wdata = rdata; e = rdata;
    q_pop = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          req_nxt = q_req;
          rsp_nxt = '0;
          rsp_nxt.status = ST_NOMATCH;
          hit_nxt = 1'b0;
          ri_nxt = '0;
          wi_nxt = '0;
          st_nxt = S_READ;
        end
      end
      S_READ: begin
        if (ri_r >= cnt_r || req_r.cmd > CMD_LOOKUP) st_nxt = S_FIN;
        else begin
          ri_nxt = ri_r + CW'(1);
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (req_r.cmd)
          CMD_ADD: if (e.dest == req_r.key_ip) hit_nxt = 1'b1;
          CMD_DELETE: begin
            if (e.dest == req_r.key_ip) hit_nxt = 1'b1;
            else begin
              we = 1'b1; waddr = wi_r[AW-1:0];
              wi_nxt = wi_r + CW'(1);
            end
          end
          CMD_TIMEOUT: if (e.hop == req_r.key_ip) begin
            hit_nxt = 1'b1; we = 1'b1; wdata.metric = HOP_INF;
          end
          CMD_UPDATE: if (e.hop == req_r.hop_ip && e.dest == req_r.key_ip) begin
            hit_nxt = 1'b1;
            if (req_r.metric_in >= 5'd17) begin
              we = 1'b1; wdata.metric = HOP_INF;
            end else if (e.metric > req_r.metric_in) begin
              we = 1'b1; wdata.metric = req_r.metric_in; wdata.ttl = TTL_FRESH;
            end
          end
          default: if (!hit_r && e.metric != 5'd0 &&
                       (e.dest & mask) == (req_r.key_ip & mask)) begin
            hit_nxt = 1'b1;
            rsp_nxt.route_dest = e.dest; rsp_nxt.route_hop = e.hop;
            rsp_nxt.route_metric = e.metric; rsp_nxt.route_ttl = e.ttl;
          end
        endcase
        if (ri_r >= cnt_r) st_nxt = S_FIN;
        else ri_nxt = ri_r + CW'(1);
      end
      S_FIN: begin
        st_nxt = S_OUT;
        unique case (req_r.cmd)
          CMD_ADD: begin
            if (hit_r) rsp_nxt.status = ST_DUP;
            else if (cnt_r == CW'(DEPTH)) rsp_nxt.status = ST_FULL;
            else begin
              we = 1'b1; waddr = cnt_r[AW-1:0];
              wdata.dest = req_r.key_ip; wdata.hop = req_r.hop_ip;
              wdata.metric = req_r.metric_in; wdata.ttl = req_r.ttl_in;
              cnt_nxt = cnt_r + CW'(1);
              rsp_nxt.status = ST_DONE;
            end
          end
          CMD_DELETE: begin
            cnt_nxt = wi_r;
            rsp_nxt.status = hit_r ? ST_DONE : ST_NOMATCH;
          end
          CMD_TIMEOUT, CMD_UPDATE, CMD_LOOKUP:
            rsp_nxt.status = hit_r ? ST_DONE : ST_NOMATCH;
          default: rsp_nxt.status = ST_NOMATCH;
        endcase
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; hit_r <= 1'b0; ri_r <= '0; wi_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; hit_r <= hit_nxt; ri_r <= ri_nxt; wi_r <= wi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_rng, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))
  `ASSERT_IMPL(a_wi_le_ri, clk, rst_n, st_r == S_SCAN, wi_r < ri_r)
endmodule

/* src/distance_vector_route_table_core.sv */
// Top level of the RIP-style route table core.
// Each request (no-ops apart) scans the N entries currently held (max TABLE_DEPTH),
// one entry per cycle, through the table RAM (one write port, one read port).
// The back end serves one request at a time; a 2-deep request queue absorbs bursts.
// Reset (rst_n low, synchronous): table empty, queue empty, lookup_mask = 0xFFFFFF00.
module distance_vector_route_table_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  dvrt_if.sink   in,
  dvrt_if.source out,
  dvrt_if.sink   cfg
);
  import dvrt_pkg::*;

  logic [31:0] mask_r;
  logic        q_valid, q_pop;
  req_t        q_req;

  // config channel always ready; user writes only while idle (core does not enforce it)
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= MASK_RST;
    else if (cfg.valid) mask_r <= cfg.data;
  end

  // front end: request queue
  dvrt_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in.valid), .in_ready(in.ready), .in_req(in.data),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  // back end: table scan engine with registered result
  dvrt_back #(.DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .mask(mask_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
    .out_valid(out.valid), .out_ready(out.ready), .out_rsp(out.data)
  );

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_mask_wr, clk, rst_n, cfg.valid, mask_r == $past(cfg.data))
endmodule
